// ----- sv/bapf_pkg.sv -----
// Package for the burst-aligned packet framer: widths, codes, defaults and the
// entry type that travels from the front end through the queue to the back end.
// No dependencies.
`default_nettype none

package bapf_pkg;

	localparam int BURST_BYTES_DEF = 12;
	localparam int MAX_PACKET_BYTES_DEF = 512;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int LEN_W = 10;
	localparam int QUOT_W = 8;
	localparam int PAD_W = 4;
	localparam int WCNT_W = 2;
	localparam int RECIP_SHIFT = 16;
	localparam int HDR_CMD_BIT = 4;

	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_ERR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [LEN_W-1:0] packet_length;
		logic [QUOT_W-1:0] quot;
		logic is_command;
		logic closes;
	} entry_t;

endpackage

`default_nettype wire

// ----- sv/bapf_ifs.sv -----
// Handshake channels of the framer: the item channel and the result channel.
// Each carries valid, ready and its payload fields; no dependencies.
`default_nettype none

interface bapf_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [7:0] data_byte;
	logic [9:0] packet_length;
	logic is_command;

	modport source(output valid, opcode, data_byte, packet_length, is_command, input ready);
	modport sink(input valid, opcode, data_byte, packet_length, is_command, output ready);
endinterface

interface bapf_out_if;
	logic valid;
	logic ready;
	logic [31:0] fifo_word;
	logic last_word;
	logic protocol_error;

	modport source(output valid, fifo_word, last_word, protocol_error, input ready);
	modport sink(input valid, fifo_word, last_word, protocol_error, output ready);
endinterface

`default_nettype wire

// ----- sv/bapf_front.sv -----
// Front end of the framer: accepts items, checks their sequence against the open
// packet and queues a classified entry. Uses bapf_pkg and bapf_in_if.
`default_nettype none

module bapf_front #(
	parameter int BURST_BYTES = bapf_pkg::BURST_BYTES_DEF,
	parameter int MAX_PACKET_BYTES = bapf_pkg::MAX_PACKET_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	bapf_in_if.sink pkt,
	input logic q_full,
	output logic q_push,
	output bapf_pkg::entry_t q_entry
);
	import bapf_pkg::*;

	localparam int RECIP = ((1 << RECIP_SHIFT) + BURST_BYTES - 1) / BURST_BYTES;
	localparam int PROD_W = LEN_W + RECIP_SHIFT;

	logic open_q;
	logic [LEN_W-1:0] remaining_q;
	logic [PROD_W-1:0] prod;
	logic accept;

	assign pkt.ready = !q_full;
	assign accept = pkt.valid && !q_full;
	assign q_push = accept;
	assign prod = PROD_W'(pkt.packet_length) * PROD_W'(RECIP);

	always_comb begin
		q_entry.data_byte = pkt.data_byte;
		q_entry.packet_length = pkt.packet_length;
		q_entry.quot = prod[RECIP_SHIFT +: QUOT_W];
		q_entry.is_command = pkt.is_command;
		q_entry.closes = (remaining_q == LEN_W'(1));
		if (pkt.opcode == OP_START) begin
			if (open_q || pkt.packet_length > LEN_W'(MAX_PACKET_BYTES))
				q_entry.kind = KIND_ERR;
			else
				q_entry.kind = KIND_START;
		end else begin
			q_entry.kind = open_q ? KIND_DATA : KIND_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			remaining_q <= '0;
		end else if (accept) begin
			if (q_entry.kind == KIND_START) begin
				open_q <= (pkt.packet_length != '0);
				remaining_q <= pkt.packet_length;
			end else if (q_entry.kind == KIND_DATA) begin
				remaining_q <= remaining_q - LEN_W'(1);
				if (q_entry.closes)
					open_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/bapf_queue.sv -----
// Short queue of classified entries between the front and back ends of the framer.
// Uses bapf_pkg for the entry type.
`default_nettype none

module bapf_queue #(
	parameter int DEPTH = bapf_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bapf_pkg::entry_t wr_entry,
	output logic full,
	input logic pop,
	output bapf_pkg::entry_t head,
	output logic empty
);
	import bapf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("Queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("Queue read while empty.");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("Queue count lost a pushed entry.");

endmodule

`default_nettype wire

// ----- sv/bapf_back.sv -----
// Back end of the framer: works off queued entries, packs bytes into 32-bit words
// and drives the registered result channel. Uses bapf_pkg and bapf_out_if.
`default_nettype none

module bapf_back #(
	parameter int BURST_BYTES = bapf_pkg::BURST_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	input bapf_pkg::entry_t head,
	input logic q_empty,
	output logic q_pop,
	bapf_out_if.source fifo
);
	import bapf_pkg::*;

	localparam int R_W = LEN_W + 2;

	logic [1:0] lane_q;
	logic [23:0] partial_q;
	logic [WCNT_W-1:0] wi_q;
	logic ovalid_q;
	logic [31:0] oword_q;
	logic olast_q;
	logic oerr_q;

	logic head_valid;
	logic out_free;
	logic out_load;
	logic [R_W-1:0] qb;
	logic [R_W-1:0] r0;
	logic [R_W-1:0] rem;
	logic [PAD_W-1:0] pad;
	logic [7:0] hdr;
	logic zero_len;
	logic [23:0] merged;
	logic [WCNT_W-1:0] nwords;
	logic [31:0] word;
	logic last;
	logic err;
	logic [1:0] lane_nx;
	logic [23:0] partial_nx;

	assign head_valid = !q_empty;
	assign out_free = !ovalid_q || fifo.ready;
	assign fifo.valid = ovalid_q;
	assign fifo.fifo_word = oword_q;
	assign fifo.last_word = olast_q;
	assign fifo.protocol_error = oerr_q;

	always_comb begin
		qb = R_W'(head.quot) * R_W'(BURST_BYTES);
		r0 = R_W'(head.packet_length) - qb;
		rem = (r0 >= R_W'(BURST_BYTES)) ? r0 - R_W'(BURST_BYTES) : r0;
		pad = PAD_W'(BURST_BYTES) - PAD_W'(rem);
		hdr = 8'(pad) | (8'(head.is_command) << HDR_CMD_BIT);
		zero_len = (head.packet_length == '0);
		case (lane_q)
			2'd0: merged = {partial_q[23:8], head.data_byte};
			2'd1: merged = {partial_q[23:16], head.data_byte, partial_q[7:0]};
			2'd2: merged = {head.data_byte, partial_q[15:0]};
			default: merged = partial_q;
		endcase

		nwords = '0;
		word = '0;
		last = 1'b0;
		err = 1'b0;
		lane_nx = lane_q;
		partial_nx = partial_q;
		case (head.kind)
			KIND_START: begin
				nwords = WCNT_W'(pad >> 2) + WCNT_W'(zero_len && pad[1:0] != 2'd0);
				word = (wi_q == '0) ? {24'd0, hdr} : 32'd0;
				last = zero_len && (wi_q == nwords - WCNT_W'(1));
				if (zero_len) begin
					lane_nx = 2'd0;
					partial_nx = '0;
				end else begin
					lane_nx = pad[1:0];
					partial_nx = ((pad >> 2) == '0) ? {16'd0, hdr} : 24'd0;
				end
			end
			KIND_DATA: begin
				nwords = WCNT_W'(lane_q == 2'd3 || head.closes);
				word = (lane_q == 2'd3) ? {head.data_byte, partial_q} : {8'd0, merged};
				last = head.closes;
				if (lane_q == 2'd3 || head.closes) begin
					lane_nx = 2'd0;
					partial_nx = '0;
				end else begin
					lane_nx = lane_q + 2'd1;
					partial_nx = merged;
				end
			end
			default: begin
				nwords = WCNT_W'(1);
				err = 1'b1;
			end
		endcase
	end

	assign out_load = head_valid && nwords != '0 && out_free;
	assign q_pop = head_valid
		&& (nwords == '0 || (out_free && wi_q == nwords - WCNT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q <= '0;
			partial_q <= '0;
			wi_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				lane_q <= lane_nx;
				partial_q <= partial_nx;
				wi_q <= '0;
			end else if (out_load) begin
				wi_q <= wi_q + WCNT_W'(1);
			end
			if (out_load)
				ovalid_q <= 1'b1;
			else if (fifo.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			oword_q <= word;
			olast_q <= last;
			oerr_q <= err;
		end
	end

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oerr_q) |-> (oword_q == '0 && !olast_q))
		else $error("Error result carries framed data.");
	a_mid_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wi_q != '0) |-> head_valid)
		else $error("Word index advanced with no entry at the queue head.");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last) |=> (lane_q == '0 && partial_q == '0))
		else $error("Packet closed with bytes left in the partial word.");

endmodule

`default_nettype wire

// ----- sv/burst_aligned_packet_framer.sv -----
// Top level of the burst-aligned packet framer: front end, entry queue, back end.
// Uses bapf_pkg, bapf_ifs, bapf_front, bapf_queue and bapf_back.
//
//   channel  role    handshake          payload
//   pkt      sink    valid / ready      opcode, data_byte, packet_length, is_command
//   fifo     source  valid / ready      fifo_word, last_word, protocol_error
//
// The front end takes one transaction per cycle while the queue has room.
// A data byte yields at most one framed word and an error one error word; a start yields
// up to ceil(BURST_BYTES / 4) framed words, all through the single output register.
// Reset is asynchronous and clears the packet state, the queue and the output valid flag.
// A stall on fifo fills the output register, then the queue, and then drops pkt.ready.
`default_nettype none

module burst_aligned_packet_framer #(
	parameter int BURST_BYTES = bapf_pkg::BURST_BYTES_DEF,
	parameter int MAX_PACKET_BYTES = bapf_pkg::MAX_PACKET_BYTES_DEF,
	parameter int QUEUE_DEPTH = bapf_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	bapf_in_if.sink pkt,
	bapf_out_if.source fifo
);
	import bapf_pkg::*;

	entry_t wr_entry;
	entry_t head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	bapf_front #(
		.BURST_BYTES(BURST_BYTES),
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt),
		.q_full(q_full),
		.q_push(q_push),
		.q_entry(wr_entry)
	);

	bapf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wr_entry(wr_entry),
		.full(q_full),
		.pop(q_pop),
		.head(head),
		.empty(q_empty)
	);

	bapf_back #(
		.BURST_BYTES(BURST_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.fifo(fifo)
	);

endmodule

`default_nettype wire

// ----- sim/burst_aligned_packet_framer_test.sv -----
// Self-checking testbench for the burst-aligned packet framer: packet items in, framed
// FIFO words out, each compared with an in-bench prediction of the framing.
// Depends on bapf_pkg, bapf_ifs and burst_aligned_packet_framer.
`default_nettype none

module burst_aligned_packet_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bapf_pkg::*;

	localparam int BURST = BURST_BYTES_DEF;
	localparam int MAX_LEN = MAX_PACKET_BYTES_DEF;
	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_ITEMS = 60;
	localparam longint TIMEOUT_NS = 5_000_000;

	typedef struct {
		logic [31:0] fifo_word;
		logic last_word;
		logic protocol_error;
	} fifo_result_t;

	logic clk;
	logic arst_n;

	bapf_in_if pkt_if();
	bapf_out_if fifo_if();

	burst_aligned_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_if),
		.fifo(fifo_if)
	);

	fifo_result_t expected_frames[$];
	fifo_result_t frame_batch[$];

	logic pkt_open;
	logic [9:0] bytes_left;
	logic [1:0] lane;
	logic [23:0] partial;

	int mismatches;
	int items_sent;
	int words_checked;
	int packets_started;
	int hold_serial;
	bit idle_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d words still expected.", expected_frames.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic void place_byte(logic [7:0] b);
		if (lane == 2'd3) begin
			frame_batch.push_back('{fifo_word: {b, partial}, last_word: 1'b0,
				protocol_error: 1'b0});
			partial = '0;
			lane = 2'd0;
		end else begin
			partial = partial | (24'(b) << (8 * lane));
			lane = lane + 2'd1;
		end
	endfunction

	function automatic void close_packet();
		if (lane != 2'd0) begin
			frame_batch.push_back('{fifo_word: {8'h00, partial}, last_word: 1'b1,
				protocol_error: 1'b0});
		end else if (frame_batch.size() > 0) begin
			frame_batch[frame_batch.size() - 1].last_word = 1'b1;
		end
		partial = '0;
		lane = 2'd0;
		bytes_left = '0;
		pkt_open = 1'b0;
	endfunction

	function automatic void predict_frames(logic op, logic [7:0] b, logic [9:0] len,
			logic cmd);
		int pad;
		frame_batch.delete();
		if (op == OP_START) begin
			if (pkt_open || int'(len) > MAX_LEN) begin
				frame_batch.push_back('{fifo_word: '0, last_word: 1'b0, protocol_error: 1'b1});
			end else begin
				pad = BURST - (int'(len) % BURST);
				partial = '0;
				lane = 2'd0;
				place_byte(8'(pad) | (cmd ? 8'(1 << HDR_CMD_BIT) : 8'h00));
				for (int i = 1; i < pad; i++) begin
					place_byte(8'h00);
				end
				bytes_left = len;
				pkt_open = 1'b1;
				if (bytes_left == '0) begin
					close_packet();
				end
			end
		end else begin
			if (!pkt_open) begin
				frame_batch.push_back('{fifo_word: '0, last_word: 1'b0, protocol_error: 1'b1});
			end else begin
				place_byte(b);
				bytes_left = bytes_left - 10'd1;
				if (bytes_left == '0) begin
					close_packet();
				end
			end
		end
		foreach (frame_batch[i]) begin
			expected_frames.push_back(frame_batch[i]);
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		fifo_result_t want;
		if (arst_n && fifo_if.valid && fifo_if.ready) begin
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected word", fifo_if.fifo_word, 0);
			end else begin
				want = expected_frames.pop_front();
				words_checked++;
				if (fifo_if.fifo_word !== want.fifo_word) begin
					report_mismatch("fifo_word", fifo_if.fifo_word, want.fifo_word);
				end
				if (fifo_if.last_word !== want.last_word) begin
					report_mismatch("last_word", fifo_if.last_word, want.last_word);
				end
				if (fifo_if.protocol_error !== want.protocol_error) begin
					report_mismatch("protocol_error", fifo_if.protocol_error,
						want.protocol_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		logic rdy;
		int hold_seen;
		int hold_left;
		int stall_left;
		rdy = 1'b1;
		if (hold_serial != hold_seen) begin
			hold_seen = hold_serial;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (idle_on) begin
			stall_left = pick_gap();
		end
		fifo_if.ready <= rdy;
	end

	task automatic send_item(logic op, logic [7:0] b, logic [9:0] len, logic cmd);
		int gap;
		pkt_if.valid <= 1'b1;
		pkt_if.opcode <= op;
		pkt_if.data_byte <= b;
		pkt_if.packet_length <= len;
		pkt_if.is_command <= cmd;
		do @(posedge clk); while (!pkt_if.ready);
		predict_frames(op, b, len, cmd);
		items_sent++;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			pkt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_start(logic [9:0] len, logic cmd);
		send_item(OP_START, 8'($urandom_range(0, 255)), len, cmd);
		packets_started++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(OP_DATA, b, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		pkt_if.valid <= 1'b0;
		do @(posedge clk); while (expected_frames.size() != 0);
	endtask

	task automatic send_packet(int len, logic cmd, bit break_in);
		int cut;
		cut = $urandom_range(0, len);
		send_start(10'(len), cmd);
		for (int i = 0; i < len; i++) begin
			if (break_in && i == cut) begin
				send_start(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
			end
			send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed();
		idle_on <= 1'b1;
		send_byte(8'hFF);
		send_start(10'd0, 1'b0);
		send_start(10'd0, 1'b1);
		send_start(10'd1023, 1'b1);
		send_start(10'd513, 1'b0);
		send_start(10'd1, 1'b1);
		send_start(10'd5, 1'b0);
		send_byte(8'h00);
		send_start(10'd11, 1'b0);
		for (int i = 0; i < 11; i++) begin
			send_byte((i % 2 == 0) ? 8'hFF : 8'h00);
		end
		send_byte(8'h5A);
		wait_drained();
	endtask

	task automatic test_backpressure();
		idle_on <= 1'b0;
		hold_serial <= hold_serial + 1;
		send_packet(40, 1'b1, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int start_count;
		int r;
		int len;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			idle_on <= ($urandom_range(0, 99) < 80);
			r = $urandom_range(0, 99);
			if (r < 85) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					len = $urandom_range(0, 15);
				end else if (r < 95) begin
					len = $urandom_range(16, 40);
				end else begin
					len = $urandom_range(41, 80);
				end
				send_packet(len, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 8);
			end else if ($urandom_range(0, 1) == 0) begin
				send_byte(8'($urandom_range(0, 255)));
			end else begin
				send_start(10'($urandom_range(MAX_LEN + 1, 1023)), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 99) < 10) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	initial begin
		int tail;
		arst_n = 1'b0;
		pkt_if.valid = 1'b0;
		pkt_if.opcode = OP_START;
		pkt_if.data_byte = '0;
		pkt_if.packet_length = '0;
		pkt_if.is_command = 1'b0;
		fifo_if.ready = 1'b0;
		pkt_open = 1'b0;
		bytes_left = '0;
		lane = 2'd0;
		partial = '0;
		idle_on = 1'b0;
		hold_serial = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_traffic();

		tail = 0;
		while (expected_frames.size() != 0 && tail < 10 * TAIL_CYCLES) begin
			@(posedge clk);
			tail++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d packet-side transactions (%0d starts) and checked %0d FIFO words,",
			items_sent, packets_started, words_checked);
		$display("including out-of-sequence items, oversized starts and a long FIFO hold-off.");
		if (mismatches == 0 && expected_frames.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d words never arrived.", mismatches,
				expected_frames.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
